>>> rtl/jet_pkg.sv
// ----------------------------------------------------------------------------
// jet_pkg
// Shared types and constants for the Julia escape-time pixel unit: payload
// structs, configuration register map, and controller/datapath links.
// ----------------------------------------------------------------------------
package jet_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int MAX_DIM    = 4096;
  localparam int COORD_W    = $clog2(MAX_DIM);
  localparam int MROW_W     = COORD_W + 1;
  localparam int WORD_W     = 32;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int SQ_W       = PROD_W - FRAC_BITS;
  localparam int MAG_W      = SQ_W + 1;
  localparam int NEXT_W     = SQ_W + 2;
  localparam int WIDE_W     = 45;
  localparam int ITER_W     = 16;
  localparam int STEP_W     = 31;
  localparam int DIM_W      = 13;
  localparam int PAL_W      = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Start of the plane, -1.5, and the escape bound, 4, in fixed point.
  localparam logic signed [WORD_W-1:0] ORIGIN = WORD_W'(-(64'sd3 <<< (FRAC_BITS - 1)));
  localparam logic [MAG_W-1:0] LIMIT4 = MAG_W'(64'd4 << FRAC_BITS);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_C_REAL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C_IMAG       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ITER     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd6;

  localparam logic [ITER_W-1:0] RST_MAX_ITER = 16'd256;
  localparam logic [STEP_W-1:0] RST_STEP     = 31'd6291456;
  localparam logic [DIM_W-1:0]  RST_DIM      = 13'd128;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_t;

  typedef struct packed {
    logic [ITER_W-1:0]  escape_count;
    logic               in_set;
    logic [PAL_W-1:0]   palette_value;
    logic [COORD_W-1:0] mirror_col;
    logic [MROW_W-1:0]  mirror_row;
  } out_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] c_real;
    logic signed [WORD_W-1:0] c_imag;
    logic [ITER_W-1:0]        max_iter;
    logic [STEP_W-1:0]        step_x;
    logic [STEP_W-1:0]        step_y;
    logic [DIM_W-1:0]         image_width;
    logic [DIM_W-1:0]         image_height;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic init;
    logic do_mul;
    logic do_upd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic escape;
  } sts_t;

  // True when a wide signed value fits the 32-bit coordinate word.
  function automatic logic fits_word(input logic [WIDE_W-1:0] v);
    return (v[WIDE_W-1:WORD_W-1] == '0) || (v[WIDE_W-1:WORD_W-1] == '1);
  endfunction

endpackage

>>> rtl/jet_cfg.sv
// ----------------------------------------------------------------------------
// jet_cfg
// Configuration register file: decodes indexed writes into the register set.
// ----------------------------------------------------------------------------
module jet_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0]   cfg_data,
  output jet_pkg::cfg_t                    cfg
);
  import jet_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.c_real       <= '0;
      cfg.c_imag       <= '0;
      cfg.max_iter     <= RST_MAX_ITER;
      cfg.step_x       <= RST_STEP;
      cfg.step_y       <= RST_STEP;
      cfg.image_width  <= RST_DIM;
      cfg.image_height <= RST_DIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_C_REAL:       cfg.c_real       <= $signed(cfg_data[WORD_W-1:0]);
        REG_C_IMAG:       cfg.c_imag       <= $signed(cfg_data[WORD_W-1:0]);
        REG_MAX_ITER:     cfg.max_iter     <= cfg_data[ITER_W-1:0];
        REG_STEP_X:       cfg.step_x       <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:       cfg.step_y       <= cfg_data[STEP_W-1:0];
        REG_IMAGE_WIDTH:  cfg.image_width  <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= cfg_data[DIM_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/jet_ctrl.sv
// ----------------------------------------------------------------------------
// jet_ctrl
// Sequencer: takes a pixel, runs start-point setup and the multiply/update
// iteration loop, and hands the result to the output register.
// ----------------------------------------------------------------------------
module jet_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  jet_pkg::sts_t sts,
  output jet_pkg::cmd_t cmd
);
  import jet_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_MUL  = 5'b00100,
    ST_UPD  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd.init   = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        // The limit and range checks happen here, before any multiply.
        if (sts.stop) begin
          state_next = ST_FIN;
        end else begin
          cmd.do_mul = 1'b1;
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd.do_upd = 1'b1;
        state_next = sts.escape ? ST_FIN : ST_MUL;
      end
      ST_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != ST_IDLE);

endmodule

>>> rtl/jet_datapath.sv
// ----------------------------------------------------------------------------
// jet_datapath
// Fixed-point datapath: start-point mapping, the three products of the
// complex square, escape test, coordinate update and the result register.
// ----------------------------------------------------------------------------
module jet_datapath (
  input  logic          clk,
  input  logic          rst,
  input  jet_pkg::cmd_t cmd,
  input  jet_pkg::cfg_t cfg,
  input  jet_pkg::in_t  in_data,
  output jet_pkg::sts_t sts,
  output jet_pkg::out_t out_data
);
  import jet_pkg::*;

  logic [COORD_W-1:0]       col_q;
  logic [COORD_W-1:0]       row_q;
  logic signed [WORD_W-1:0] wx;
  logic signed [WORD_W-1:0] wy;
  logic                     wide;
  logic [ITER_W-1:0]        count;
  logic signed [PROD_W-1:0] pxx;
  logic signed [PROD_W-1:0] pyy;
  logic signed [PROD_W-1:0] pxy;

  logic [COORD_W+STEP_W-1:0] prod_x;
  logic [COORD_W+STEP_W-1:0] prod_y;
  logic signed [WIDE_W-1:0]  start_x;
  logic signed [WIDE_W-1:0]  start_y;
  logic [SQ_W-1:0]           sq_x;
  logic [SQ_W-1:0]           sq_y;
  logic [MAG_W-1:0]          mag;
  logic signed [NEXT_W-1:0]  nx;
  logic signed [NEXT_W-1:0]  ny;
  logic                      next_wide;
  logic                      at_limit;

  // Start point: -1.5 plus index times step, formed exactly.
  assign prod_x  = {{STEP_W{1'b0}}, col_q} * {{COORD_W{1'b0}}, cfg.step_x};
  assign prod_y  = {{STEP_W{1'b0}}, row_q} * {{COORD_W{1'b0}}, cfg.step_y};
  assign start_x = $signed({2'b00, prod_x}) + $signed({{(WIDE_W-WORD_W){ORIGIN[WORD_W-1]}}, ORIGIN});
  assign start_y = $signed({2'b00, prod_y}) + $signed({{(WIDE_W-WORD_W){ORIGIN[WORD_W-1]}}, ORIGIN});

  // Squares are never negative, so a plain right shift truncates them.
  assign sq_x = pxx[PROD_W-1:FRAC_BITS];
  assign sq_y = pyy[PROD_W-1:FRAC_BITS];
  assign mag  = {1'b0, sq_x} + {1'b0, sq_y};

  assign nx = $signed({2'b00, sq_x}) - $signed({2'b00, sq_y})
            + $signed({{(NEXT_W-WORD_W){cfg.c_real[WORD_W-1]}}, cfg.c_real});
  // Dropping one fewer fraction bit doubles the cross term; the arithmetic
  // slice rounds toward minus infinity.
  assign ny = $signed({pxy[PROD_W-1], pxy[PROD_W-1:FRAC_BITS-1]})
            + $signed({{(NEXT_W-WORD_W){cfg.c_imag[WORD_W-1]}}, cfg.c_imag});

  assign next_wide = !fits_word({{(WIDE_W-NEXT_W){nx[NEXT_W-1]}}, nx})
                  || !fits_word({{(WIDE_W-NEXT_W){ny[NEXT_W-1]}}, ny});

  assign at_limit   = (count == cfg.max_iter);
  assign sts.stop   = wide || at_limit;
  assign sts.escape = (mag > LIMIT4);

  always_ff @(posedge clk) begin
    if (rst) begin
      wide  <= 1'b0;
      count <= '0;
    end else if (cmd.init) begin
      wide  <= !fits_word(start_x) || !fits_word(start_y);
      count <= '0;
    end else if (cmd.do_upd && !sts.escape) begin
      wide  <= next_wide;
      count <= count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      col_q <= in_data.col;
      row_q <= in_data.row;
    end
    if (cmd.init) begin
      wx <= start_x[WORD_W-1:0];
      wy <= start_y[WORD_W-1:0];
    end else if (cmd.do_upd && !sts.escape) begin
      wx <= nx[WORD_W-1:0];
      wy <= ny[WORD_W-1:0];
    end
    if (cmd.do_mul) begin
      pxx <= wx * wx;
      pyy <= wy * wy;
      pxy <= wx * wy;
    end
    if (cmd.load_out) begin
      out_data.escape_count  <= count;
      out_data.in_set        <= at_limit;
      out_data.palette_value <= count[PAL_W-1:0] + 1'b1;
      out_data.mirror_col    <= COORD_W'(cfg.image_width - {1'b0, col_q} - 1'b1);
      out_data.mirror_row    <= MROW_W'(cfg.image_height - {1'b0, row_q});
    end
  end

endmodule

>>> rtl/julia_escape_time_pixel_unit.sv
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit
// Julia-set escape-time engine for one pixel at a time.
// ----------------------------------------------------------------------------
// The input channel takes one beat per pixel (column, row); the output channel
// returns one beat with the escape count, in-set flag, palette value and the
// mirrored column and row. Both channels move a beat when valid is high and
// stall is low. The configuration port writes c, the iteration limit, the
// start-point steps and the image size; write it only while the unit is idle.
// Each pixel is processed alone. After the input beat, the INIT state maps the
// start point, then every iteration runs the MUL state (the three 32x32
// products), then the UPD state (the escape test and coordinate update).
// A finished result sits in the output register while the next pixel is
// accepted and computed; if the receiver still stalls when that pixel is
// done, the unit waits and holds the input stalled. Synchronous reset clears
// the sequencer and output valid and restores the register defaults.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  jet_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output jet_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [jet_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jet_pkg::CFG_DATA_W-1:0] cfg_data
);
  import jet_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  jet_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  jet_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  jet_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .cfg      (cfg),
    .in_data  (in_data),
    .sts      (sts),
    .out_data (out_data)
  );

  // An accepted pixel keeps the input stalled while it is processed.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after accepting a pixel");

  // A result never overwrites one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || !out_stall))
    else $error("result register overwritten while stalled");

  // Every update works on products made in the cycle before.
  a_upd_after_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.do_upd |-> $past(cmd.do_mul))
    else $error("update without preceding multiply");

  // Commands are exclusive.
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cmd))
    else $error("more than one datapath command at once");

endmodule

>>> tb/sv/julia_escape_time_pixel_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// julia_escape_time_pixel_unit_test
// Self-checking bench for the Julia escape-time pixel unit. Pixel beats are
// queued by a stimulus process and fed to the unit by a clocked driver. A
// clocked monitor predicts the escape count, in-set flag, palette value and
// mirrored position of every accepted pixel with a fixed-point model of its
// own, then checks each returned beat against the oldest prediction. The
// run walks through many register settings and through phases with and
// without random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module julia_escape_time_pixel_unit_test;
  import jet_pkg::*;

  localparam longint PLANE_START = -(longint'(3) <<< (FRAC_BITS - 1));
  localparam longint ESCAPE_BOUND = longint'(4) <<< FRAC_BITS;
  localparam longint WORD_MIN = -(longint'(1) <<< (WORD_W - 1));
  localparam longint WORD_MAX = (longint'(1) <<< (WORD_W - 1)) - 1;
  localparam logic [31:0] PLANE_SPAN = 32'd805306368;
  localparam int C_SPAN = 241591910;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam longint TIMEOUT_NS = 64'd48_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadow used by the predictor.
  logic signed [WORD_W-1:0] c_re_q;
  logic signed [WORD_W-1:0] c_im_q;
  logic [ITER_W-1:0] lim_q;
  logic [STEP_W-1:0] step_x_q;
  logic [STEP_W-1:0] step_y_q;
  logic [DIM_W-1:0] width_q;
  logic [DIM_W-1:0] height_q;

  in_t pixel_q[$];
  out_t escape_q[$];
  bit in_beat = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int mismatches = 0;

  julia_escape_time_pixel_unit uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit in_word(input longint v);
    return (v >= WORD_MIN) && (v <= WORD_MAX);
  endfunction

  function automatic out_t escape_time(input in_t px);
    longint wx, wy, sq_x, sq_y, nx, ny;
    bit gone;
    int unsigned n;
    out_t r;
    wx = PLANE_START + longint'(px.col) * longint'(step_x_q);
    wy = PLANE_START + longint'(px.row) * longint'(step_y_q);
    gone = !in_word(wx) || !in_word(wy);
    for (n = 0; n < lim_q; n++) begin
      // A coordinate that left the word range escapes at the next test.
      if (gone) break;
      sq_x = (wx * wx) >>> FRAC_BITS;
      sq_y = (wy * wy) >>> FRAC_BITS;
      if (sq_x + sq_y > ESCAPE_BOUND) break;
      // Arithmetic shift of the doubled cross term rounds toward minus infinity.
      ny = ((wx * wy) >>> (FRAC_BITS - 1)) + longint'(c_im_q);
      nx = sq_x - sq_y + longint'(c_re_q);
      if (!in_word(nx) || !in_word(ny)) gone = 1'b1;
      wx = nx;
      wy = ny;
    end
    r.escape_count = n[ITER_W-1:0];
    r.in_set = (n == lim_q);
    r.palette_value = PAL_W'(n + 1);
    r.mirror_col = COORD_W'(int'(width_q) - int'(px.col) - 1);
    r.mirror_row = MROW_W'(int'(height_q) - int'(px.row));
    return r;
  endfunction

  task automatic note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      note_error($sformatf("%s mismatch: expected %0d, got %0d", name, want, got));
  endtask

  task automatic set_mode(input int m);
    case (m)
      0: begin idle_pct = 0; stall_pct = 0; end
      1: begin idle_pct = 72; stall_pct = 0; end
      2: begin idle_pct = 0; stall_pct = 72; end
      default: begin idle_pct = 35; stall_pct = 35; end
    endcase
  endtask

  // Writes are issued on consecutive falling edges; the enable drops only
  // once a whole group is done.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_C_REAL: c_re_q = val;
      REG_C_IMAG: c_im_q = val;
      REG_MAX_ITER: lim_q = val[ITER_W-1:0];
      REG_STEP_X: step_x_q = val[STEP_W-1:0];
      REG_STEP_Y: step_y_q = val[STEP_W-1:0];
      REG_IMAGE_WIDTH: width_q = val[DIM_W-1:0];
      REG_IMAGE_HEIGHT: height_q = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_all(input logic [31:0] cr, ci, lim, sx, sy, w, h);
    write_reg(REG_C_REAL, cr);
    write_reg(REG_C_IMAG, ci);
    write_reg(REG_MAX_ITER, lim);
    write_reg(REG_STEP_X, sx);
    write_reg(REG_STEP_Y, sy);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_pixel(input int col, input int row);
    in_t px;
    px.col = COORD_W'(col);
    px.row = COORD_W'(row);
    pixel_q.push_back(px);
  endtask

  // Holds until every queued pixel has been sent and answered.
  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_valid || escape_q.size() != 0) begin
      @(posedge clk);
      #1;
    end
    repeat (16) @(posedge clk);
    #1;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_beat) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data <= pixel_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst) begin
      in_beat = 1'b0;
    end else begin
      in_beat = in_valid && !in_stall;
      if (in_beat) escape_q.push_back(escape_time(in_data));
      if (out_valid && !out_stall) begin
        if (escape_q.size() == 0) begin
          note_error("result beat with no pixel pending");
        end else begin
          want = escape_q.pop_front();
          check_field("escape_count", 32'(out_data.escape_count), 32'(want.escape_count));
          check_field("in_set", 32'(out_data.in_set), 32'(want.in_set));
          check_field("palette_value", 32'(out_data.palette_value),
                      32'(want.palette_value));
          check_field("mirror_col", 32'(out_data.mirror_col), 32'(want.mirror_col));
          check_field("mirror_row", 32'(out_data.mirror_row), 32'(want.mirror_row));
        end
      end
    end
  end

  initial begin : stimulus
    int p, k, w, h;
    logic [31:0] cr, ci, lim;
    bit wild;
    c_re_q = '0;
    c_im_q = '0;
    lim_q = RST_MAX_ITER;
    step_x_q = RST_STEP;
    step_y_q = RST_STEP;
    width_q = RST_DIM;
    height_q = RST_DIM;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Register defaults: origin point in the set, corners, far corners that
    // start out of range, and pixels outside the image.
    set_mode(0);
    add_pixel(64, 64);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    add_pixel(4095, 0);
    add_pixel(0, 4095);
    add_pixel(127, 127);
    add_pixel(32, 64);
    add_pixel(100, 64);
    add_pixel(120, 64);
    add_pixel(128, 0);
    add_pixel(0, 200);
    wait_idle();

    // Zero iteration limit.
    set_mode(1);
    set_all(0, 0, 0, 32'(RST_STEP), 32'(RST_STEP), 32'(RST_DIM), 32'(RST_DIM));
    add_pixel(64, 64);
    add_pixel(0, 0);
    add_pixel(4095, 4095);
    wait_idle();

    // Largest c_real pushes an update out of range; the limit of one step
    // is reached before the escape test sees it.
    set_mode(2);
    set_all(32'h7FFF_FFFF, 0, 1, 32'(RST_STEP), 32'(RST_STEP), 32'(RST_DIM),
            32'(RST_DIM));
    add_pixel(64, 64);
    add_pixel(146, 64);
    wait_idle();

    set_mode(3);
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF, 0, 32'h7FFF_FFFF, 4096, 4096);
    add_pixel(0, 0);
    add_pixel(4095, 1);
    add_pixel(0, 2);
    add_pixel(4095, 4095);
    wait_idle();

    // Longest limit with a fixed point at the origin; the spare index must
    // leave every register alone.
    set_mode(0);
    write_reg(REG_SPARE, $urandom);
    set_all(0, 0, 32'hFFFF, 32'(RST_STEP), 32'(RST_STEP), 32'h1FFF, 0);
    add_pixel(64, 64);
    add_pixel(0, 0);
    wait_idle();

    set_mode(2);
    set_all(0, 32'h8000_0000, 2, 0, 32'(RST_STEP), 4096, 4096);
    add_pixel(0, 64);
    add_pixel(4095, 100);
    wait_idle();

    for (p = 0; p < 25; p++) begin
      set_mode(p % 4);
      wild = (p % 5 == 3);
      if (wild) begin
        w = 4096;
        h = 4096;
        set_all($urandom, $urandom, $urandom_range(1, 24), $urandom, $urandom,
                $urandom, $urandom);
      end else begin
        if (p % 5 == 4) begin
          w = (p % 2) ? 1 : 4096;
          h = (p % 2) ? 4096 : 1;
        end else begin
          w = $urandom_range(4, 400);
          h = $urandom_range(4, 400);
        end
        cr = $urandom_range(0, 2 * C_SPAN) - C_SPAN;
        ci = $urandom_range(0, 2 * C_SPAN) - C_SPAN;
        lim = (p == 12) ? 256 : $urandom_range(1, 40);
        set_all(cr, ci, lim, PLANE_SPAN / w, PLANE_SPAN / h, w, h);
      end
      // Mostly pixels inside the image, where the orbits are interesting.
      for (k = 0; k < 60; k++) begin
        if (!wild && $urandom_range(99) < 85)
          add_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1));
        else
          add_pixel($urandom_range(0, 4095), $urandom_range(0, 4095));
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
